// ===== sv/nsv_pkg.sv =====
// Shared constants, function codes and the queued item type of the Voronoi seed search block.
package nsv_pkg;

	localparam int MAX_POINTS = 128;
	localparam int COORD_BITS = 12;

	localparam int ADDR_W  = $clog2(MAX_POINTS);
	localparam int NP_W    = $clog2(MAX_POINTS + 1);
	localparam int IDX_W   = 7;
	localparam int COLOR_W = 8;
	localparam int CFG_W   = 8;
	localparam int COUNT_W = 24;
	localparam int FUNC_W  = 2;
	localparam int SQ_W    = 2 * COORD_BITS;
	localparam int DIST_W  = 2 * COORD_BITS + 1;
	localparam int SEED_W  = 2 * COORD_BITS + 3 * COLOR_W;
	localparam int Q_DEPTH = 2;
	localparam int QP_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

	localparam logic [FUNC_W-1:0] FUNC_LOAD     = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLASSIFY = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY    = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_BAD      = 2'd3;

	localparam logic [CFG_W-1:0]   NUM_POINTS_RST = 8'd100;
	localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

	typedef struct packed {
		logic [FUNC_W-1:0]     op;
		logic                  err;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [IDX_W-1:0]      idx;
		logic [COLOR_W-1:0]    red;
		logic [COLOR_W-1:0]    green;
		logic [COLOR_W-1:0]    blue;
	} item_t;

endpackage

// ===== sv/nsv_front.sv =====
// Front end: takes requests, flags bad ones and holds them in a short queue.
module nsv_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [nsv_pkg::FUNC_W-1:0]          func,
	input  logic [11:0]                         coord_x,
	input  logic [11:0]                         coord_y,
	input  logic [nsv_pkg::IDX_W-1:0]           point_index,
	input  logic [nsv_pkg::COLOR_W-1:0]         seed_red,
	input  logic [nsv_pkg::COLOR_W-1:0]         seed_green,
	input  logic [nsv_pkg::COLOR_W-1:0]         seed_blue,
	output nsv_pkg::item_t                      q_item,
	output logic                                q_valid,
	input  logic                                q_pop
);

	nsv_pkg::item_t               fifo_q [nsv_pkg::Q_DEPTH];
	nsv_pkg::item_t               in_item;
	logic [nsv_pkg::QP_W-1:0]     wr_ptr_q;
	logic [nsv_pkg::QP_W-1:0]     rd_ptr_q;
	logic [nsv_pkg::QP_W:0]       fill_q;
	logic                         push;
	logic                         idx_bad;

	assign busy    = (fill_q == (nsv_pkg::QP_W + 1)'(nsv_pkg::Q_DEPTH));
	assign push    = start && !busy;
	assign q_valid = (fill_q != '0);
	assign q_item  = fifo_q[rd_ptr_q];
	assign idx_bad = (int'(point_index) >= nsv_pkg::MAX_POINTS);

	always_comb begin
		in_item.op    = func;
		in_item.x     = nsv_pkg::COORD_BITS'(coord_x);
		in_item.y     = nsv_pkg::COORD_BITS'(coord_y);
		in_item.idx   = point_index;
		in_item.red   = seed_red;
		in_item.green = seed_green;
		in_item.blue  = seed_blue;
		case (func)
			nsv_pkg::FUNC_LOAD:     in_item.err = idx_bad;
			nsv_pkg::FUNC_QUERY:    in_item.err = idx_bad;
			nsv_pkg::FUNC_CLASSIFY: in_item.err = 1'b0;
			default:                in_item.err = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == nsv_pkg::QP_W'(nsv_pkg::Q_DEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == nsv_pkg::QP_W'(nsv_pkg::Q_DEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== sv/nsv_back.sv =====
// Back end: seed and count memories, the nearest-seed scan pipeline and the result registers.
module nsv_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [nsv_pkg::CFG_W-1:0]           cfg_wr_data,
	input  nsv_pkg::item_t                      q_item,
	input  logic                                q_valid,
	output logic                                q_pop,
	output logic                                done,
	output logic                                status,
	output logic [nsv_pkg::IDX_W-1:0]           cell_res,
	output logic [nsv_pkg::COLOR_W-1:0]         red,
	output logic [nsv_pkg::COLOR_W-1:0]         green,
	output logic [nsv_pkg::COLOR_W-1:0]         blue,
	output logic [nsv_pkg::COUNT_W-1:0]         pixel_count
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_FETCH  = 3'd2;
	localparam logic [2:0] ST_UPDATE = 3'd3;
	localparam logic [2:0] ST_QUERY  = 3'd4;

	localparam int CB = nsv_pkg::COORD_BITS;
	localparam int CW = nsv_pkg::COLOR_W;
	localparam int SW = nsv_pkg::SEED_W;

	logic [2:0]                        state_q;
	logic [nsv_pkg::CFG_W-1:0]         num_points_q;
	nsv_pkg::item_t                    it_q;
	logic [nsv_pkg::NP_W-1:0]          n_q;
	logic [nsv_pkg::NP_W-1:0]          cnt_q;

	logic [SW-1:0]                     seed_mem [nsv_pkg::MAX_POINTS];
	logic [SW-1:0]                     seed_rd_q;
	logic [nsv_pkg::COUNT_W-1:0]       cnt_mem [nsv_pkg::MAX_POINTS];
	logic [nsv_pkg::COUNT_W-1:0]       cnt_rd_q;
	logic [nsv_pkg::MAX_POINTS-1:0]    cnt_vld_q;
	logic                              vld_rd_q;

	logic                              v_s2;
	logic [nsv_pkg::ADDR_W-1:0]        idx_s2;
	logic                              v_s3;
	logic [nsv_pkg::ADDR_W-1:0]        idx_s3;
	logic [nsv_pkg::SQ_W-1:0]          sqx_s3;
	logic [nsv_pkg::SQ_W-1:0]          sqy_s3;

	logic [nsv_pkg::ADDR_W-1:0]        best_q;
	logic [nsv_pkg::DIST_W-1:0]        best_d_q;
	logic                              first_q;

	logic                              issue;
	logic [nsv_pkg::NP_W-1:0]          n_eff;
	logic [nsv_pkg::ADDR_W-1:0]        head_addr;
	logic [nsv_pkg::ADDR_W-1:0]        seed_raddr;
	logic [nsv_pkg::ADDR_W-1:0]        cnt_raddr;
	logic                              seed_we;
	logic                              cnt_we;
	logic [nsv_pkg::ADDR_W-1:0]        cnt_waddr;
	logic [nsv_pkg::COUNT_W-1:0]       cnt_wdata;
	logic [nsv_pkg::COUNT_W-1:0]       new_count;
	logic [CB-1:0]                     seed_x_rd;
	logic [CB-1:0]                     seed_y_rd;
	logic [CB-1:0]                     dx;
	logic [CB-1:0]                     dy;
	logic [nsv_pkg::DIST_W-1:0]        dist_sum;

	assign q_pop      = (state_q == ST_IDLE) && q_valid;
	assign issue      = (state_q == ST_SCAN) && (cnt_q < n_q);
	assign n_eff      = (int'(num_points_q) > nsv_pkg::MAX_POINTS)
		? nsv_pkg::NP_W'(nsv_pkg::MAX_POINTS) : nsv_pkg::NP_W'(num_points_q);
	assign head_addr  = nsv_pkg::ADDR_W'(q_item.idx);
	assign seed_raddr = (state_q == ST_SCAN) ? cnt_q[nsv_pkg::ADDR_W-1:0] : best_q;
	assign cnt_raddr  = (state_q == ST_IDLE) ? head_addr : best_q;
	assign seed_we    = q_pop && (q_item.op == nsv_pkg::FUNC_LOAD) && !q_item.err;
	assign cnt_we     = seed_we || (state_q == ST_UPDATE);
	assign cnt_waddr  = seed_we ? head_addr : best_q;
	assign cnt_wdata  = seed_we ? '0 : new_count;
	assign new_count  = !vld_rd_q ? nsv_pkg::COUNT_W'(1)
		: ((cnt_rd_q == nsv_pkg::COUNT_MAX) ? cnt_rd_q : cnt_rd_q + 1'b1);
	assign seed_x_rd  = seed_rd_q[SW-1 -: CB];
	assign seed_y_rd  = seed_rd_q[SW-CB-1 -: CB];
	assign dx         = (it_q.x >= seed_x_rd) ? it_q.x - seed_x_rd : seed_x_rd - it_q.x;
	assign dy         = (it_q.y >= seed_y_rd) ? it_q.y - seed_y_rd : seed_y_rd - it_q.y;
	assign dist_sum   = nsv_pkg::DIST_W'(sqx_s3) + nsv_pkg::DIST_W'(sqy_s3);

	always_ff @(posedge clk) begin
		if (seed_we) begin
			seed_mem[head_addr] <= {q_item.x, q_item.y, q_item.red, q_item.green, q_item.blue};
		end
		seed_rd_q <= seed_mem[seed_raddr];
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		cnt_rd_q <= cnt_mem[cnt_raddr];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			it_q <= q_item;
		end
		idx_s2 <= cnt_q[nsv_pkg::ADDR_W-1:0];
		idx_s3 <= idx_s2;
		sqx_s3 <= nsv_pkg::SQ_W'(dx) * nsv_pkg::SQ_W'(dx);
		sqy_s3 <= nsv_pkg::SQ_W'(dy) * nsv_pkg::SQ_W'(dy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			num_points_q <= nsv_pkg::NUM_POINTS_RST;
			n_q          <= '0;
			cnt_q        <= '0;
			cnt_vld_q    <= '0;
			vld_rd_q     <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			best_q       <= '0;
			best_d_q     <= '0;
			first_q      <= 1'b0;
			done         <= 1'b0;
			status       <= 1'b0;
			cell_res     <= '0;
			red          <= '0;
			green        <= '0;
			blue         <= '0;
			pixel_count  <= '0;
		end else begin
			if (cfg_wr_en) begin
				num_points_q <= cfg_wr_data;
			end
			if (cnt_we) begin
				cnt_vld_q[cnt_waddr] <= 1'b1;
			end
			vld_rd_q <= cnt_vld_q[cnt_raddr];
			v_s2     <= issue;
			v_s3     <= v_s2;
			if (v_s3 && (first_q || dist_sum < best_d_q)) begin
				best_q   <= idx_s3;
				best_d_q <= dist_sum;
				first_q  <= 1'b0;
			end

			done        <= 1'b0;
			status      <= 1'b0;
			cell_res    <= '0;
			red         <= '0;
			green       <= '0;
			blue        <= '0;
			pixel_count <= '0;

			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_item.err) begin
							done   <= 1'b1;
							status <= 1'b1;
						end else begin
							case (q_item.op)
								nsv_pkg::FUNC_LOAD: begin
									done     <= 1'b1;
									cell_res <= q_item.idx;
									red      <= q_item.red;
									green    <= q_item.green;
									blue     <= q_item.blue;
								end
								nsv_pkg::FUNC_CLASSIFY: begin
									if (n_eff == '0) begin
										done   <= 1'b1;
										status <= 1'b1;
									end else begin
										n_q     <= n_eff;
										cnt_q   <= '0;
										first_q <= 1'b1;
										state_q <= ST_SCAN;
									end
								end
								nsv_pkg::FUNC_QUERY: begin
									state_q <= ST_QUERY;
								end
								default: begin
									done   <= 1'b1;
									status <= 1'b1;
								end
							endcase
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!v_s2 && !v_s3) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					done        <= 1'b1;
					cell_res    <= nsv_pkg::IDX_W'(best_q);
					red         <= seed_rd_q[3*CW-1 -: CW];
					green       <= seed_rd_q[2*CW-1 -: CW];
					blue        <= seed_rd_q[CW-1:0];
					pixel_count <= new_count;
					state_q     <= ST_IDLE;
				end
				ST_QUERY: begin
					done        <= 1'b1;
					cell_res    <= it_q.idx;
					pixel_count <= vld_rd_q ? cnt_rd_q : '0;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/nearest_seed_voronoi_pixel_top.sv =====
// Top level of the Voronoi nearest-seed search: request queue in front, seed search behind.
// A load, a bad request or an empty search is answered from the queue head as it is popped.
// A count query uses the query state; a pixel scans one seed per cycle, then fetch and update.
// Up to two requests queue while the search runs; busy is high only when the queue is full.
// Reset clears the queue, every pixel count and sets num_points to 100; seeds are not cleared.
// Each result shows for one cycle under done and must be taken then.
module nearest_seed_voronoi_pixel_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [nsv_pkg::FUNC_W-1:0]          func,
	input  logic [11:0]                         coord_x,
	input  logic [11:0]                         coord_y,
	input  logic [nsv_pkg::IDX_W-1:0]           point_index,
	input  logic [nsv_pkg::COLOR_W-1:0]         seed_red,
	input  logic [nsv_pkg::COLOR_W-1:0]         seed_green,
	input  logic [nsv_pkg::COLOR_W-1:0]         seed_blue,
	input  logic                                cfg_wr_en,
	input  logic [nsv_pkg::CFG_W-1:0]           cfg_wr_data,
	output logic                                done,
	output logic                                status,
	output logic [nsv_pkg::IDX_W-1:0]           cell_res,
	output logic [nsv_pkg::COLOR_W-1:0]         red,
	output logic [nsv_pkg::COLOR_W-1:0]         green,
	output logic [nsv_pkg::COLOR_W-1:0]         blue,
	output logic [nsv_pkg::COUNT_W-1:0]         pixel_count
);

	nsv_pkg::item_t q_item;
	logic           q_valid;
	logic           q_pop;

	nsv_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.point_index (point_index),
		.seed_red    (seed_red),
		.seed_green  (seed_green),
		.seed_blue   (seed_blue),
		.q_item      (q_item),
		.q_valid     (q_valid),
		.q_pop       (q_pop)
	);

	nsv_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_item      (q_item),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.done        (done),
		.status      (status),
		.cell_res    (cell_res),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.pixel_count (pixel_count)
	);

endmodule

// ===== sv/nsv_checker.sv =====
// Port-level assertions for the Voronoi seed search top level, with the bind that attaches them.
module nsv_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                done,
	input logic                                status,
	input logic [nsv_pkg::IDX_W-1:0]           cell_res,
	input logic [nsv_pkg::COLOR_W-1:0]         red,
	input logic [nsv_pkg::COLOR_W-1:0]         green,
	input logic [nsv_pkg::COLOR_W-1:0]         blue,
	input logic [nsv_pkg::COUNT_W-1:0]         pixel_count
);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> cell_res == '0 && red == '0 && green == '0 && blue == '0
			&& pixel_count == '0)
		else $error("error result carries non-zero fields");

	a_no_result_at_release: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !done)
		else $error("result strobe straight after reset");

	a_busy_needs_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose without an accepted request");

	a_quiet_between_results: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !status && cell_res == '0 && red == '0 && green == '0 && blue == '0
			&& pixel_count == '0)
		else $error("result ports not cleared outside a result strobe");

endmodule

bind nearest_seed_voronoi_pixel_top nsv_checker u_nsv_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the Voronoi seed search: a request table, then random traffic.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nsv_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int NUM_DIRECTED = 21;

	typedef struct packed {
		logic [FUNC_W-1:0]  op;
		logic [11:0]        x;
		logic [11:0]        y;
		logic [IDX_W-1:0]   idx;
		logic [COLOR_W-1:0] r, g, b;
	} request_t;

	typedef struct packed {
		logic               err;
		logic [IDX_W-1:0]   cell_no;
		logic [COLOR_W-1:0] r, g, b;
		logic [COUNT_W-1:0] cnt;
	} answer_t;

	typedef struct packed {
		logic       set_np;
		logic [7:0] np;
		request_t   rq;
		logic       typed;
		answer_t    ans;
	} step_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [FUNC_W-1:0]    func;
	logic [11:0]          coord_x;
	logic [11:0]          coord_y;
	logic [IDX_W-1:0]     point_index;
	logic [COLOR_W-1:0]   seed_red;
	logic [COLOR_W-1:0]   seed_green;
	logic [COLOR_W-1:0]   seed_blue;
	logic                 cfg_wr_en;
	logic [CFG_W-1:0]     cfg_wr_data;
	logic                 done;
	logic                 status;
	logic [IDX_W-1:0]     cell_res;
	logic [COLOR_W-1:0]   red;
	logic [COLOR_W-1:0]   green;
	logic [COLOR_W-1:0]   blue;
	logic [COUNT_W-1:0]   pixel_count;

	logic [11:0]          seed_x [MAX_POINTS];
	logic [11:0]          seed_y [MAX_POINTS];
	logic [23:0]          seed_rgb [MAX_POINTS];
	logic [COUNT_W-1:0]   cell_hits [MAX_POINTS];
	logic [7:0]           np_setting;

	answer_t              awaited_answers [$];

	int n_load, n_pixel, n_empty, n_query, n_bad, n_cfg, n_checked, n_fail;
	int burst_left;
	int cycles;

	nearest_seed_voronoi_pixel_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.point_index (point_index),
		.seed_red    (seed_red),
		.seed_green  (seed_green),
		.seed_blue   (seed_blue),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.done        (done),
		.status      (status),
		.cell_res    (cell_res),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.pixel_count (pixel_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic request_t req(logic [FUNC_W-1:0] op, int x, int y, int idx,
		int r, int g, int b);
		request_t rq;
		rq.op  = op;
		rq.x   = 12'(x);
		rq.y   = 12'(y);
		rq.idx = 7'(idx);
		rq.r   = 8'(r);
		rq.g   = 8'(g);
		rq.b   = 8'(b);
		return rq;
	endfunction

	function automatic answer_t ans(int err, int cell_no, int r, int g, int b, int cnt);
		answer_t a;
		a.err     = 1'(err);
		a.cell_no = 7'(cell_no);
		a.r       = 8'(r);
		a.g       = 8'(g);
		a.b       = 8'(b);
		a.cnt     = 24'(cnt);
		return a;
	endfunction

	function automatic string answer_text(answer_t a);
		return $sformatf("status=%0d cell=%0d rgb=%h_%h_%h count=%0d",
			a.err, a.cell_no, a.r, a.g, a.b, a.cnt);
	endfunction

	// Works out the result of one request and applies it to the seed table and pixel counts.
	function automatic answer_t voronoi_answer(request_t rq);
		answer_t a;
		int      n, best, dx, dy, i;
		longint  sq_dist, best_dist;
		a = '0;
		case (rq.op)
			FUNC_LOAD: begin
				seed_x[rq.idx]    = rq.x;
				seed_y[rq.idx]    = rq.y;
				seed_rgb[rq.idx]  = {rq.r, rq.g, rq.b};
				cell_hits[rq.idx] = '0;
				a.cell_no = rq.idx;
				a.r       = rq.r;
				a.g       = rq.g;
				a.b       = rq.b;
			end
			FUNC_CLASSIFY: begin
				n = (np_setting > MAX_POINTS) ? MAX_POINTS : int'(np_setting);
				if (n == 0) begin
					a.err = 1'b1;
				end else begin
					best      = 0;
					best_dist = 0;
					for (i = 0; i < n; i++) begin
						dx      = int'(rq.x) - int'(seed_x[i]);
						dy      = int'(rq.y) - int'(seed_y[i]);
						sq_dist = longint'(dx * dx) + longint'(dy * dy);
						if (i == 0 || sq_dist < best_dist) begin
							best_dist = sq_dist;
							best      = i;
						end
					end
					if (cell_hits[best] != COUNT_MAX)
						cell_hits[best] = cell_hits[best] + 1'b1;
					a.cell_no       = 7'(best);
					{a.r, a.g, a.b} = seed_rgb[best];
					a.cnt           = cell_hits[best];
				end
			end
			FUNC_QUERY: begin
				a.cell_no = rq.idx;
				a.cnt     = cell_hits[rq.idx];
			end
			default: begin
				a.err = 1'b1;
			end
		endcase
		return a;
	endfunction

	function automatic logic [11:0] rand_coord();
		case ($urandom_range(0, 7))
			0:       return 12'd0;
			1:       return 12'd4095;
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic logic [11:0] jitter(logic [11:0] c);
		int v;
		v = int'(c) + int'($urandom_range(0, 32)) - 16;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return 12'(v);
	endfunction

	function automatic int searched_seeds();
		return (np_setting > MAX_POINTS) ? MAX_POINTS : int'(np_setting);
	endfunction

	// A seed load with random content; now and then it lands on an existing seed to force ties.
	function automatic request_t random_load(int idx);
		request_t rq;
		int       k;
		rq     = req(FUNC_LOAD, 0, 0, idx, $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255));
		rq.x   = rand_coord();
		rq.y   = rand_coord();
		if (idx > 0 && $urandom_range(0, 4) == 0) begin
			k    = $urandom_range(0, idx - 1);
			rq.x = seed_x[k];
			rq.y = seed_y[k];
		end
		return rq;
	endfunction

	function automatic request_t random_request();
		request_t rq;
		int       pick, n, k;
		n    = searched_seeds();
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			rq = req(FUNC_CLASSIFY, 0, 0, $urandom_range(0, 127), $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 255));
			if (n > 0 && $urandom_range(0, 1) == 0) begin
				k    = $urandom_range(0, n - 1);
				rq.x = jitter(seed_x[k]);
				rq.y = jitter(seed_y[k]);
			end else begin
				rq.x = rand_coord();
				rq.y = rand_coord();
			end
		end else if (pick < 80) begin
			rq = random_load($urandom_range(0, MAX_POINTS - 1));
		end else if (pick < 94) begin
			k  = (n > 0 && $urandom_range(0, 1) == 0) ? $urandom_range(0, n - 1) :
				$urandom_range(0, 127);
			rq = req(FUNC_QUERY, $urandom_range(0, 4095), $urandom_range(0, 4095), k,
				$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
		end else begin
			rq = req(FUNC_BAD, $urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 127), $urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255));
		end
		return rq;
	endfunction

	task automatic send_request(request_t rq, logic typed, answer_t typed_ans);
		answer_t a;
		start       <= 1'b1;
		func        <= rq.op;
		coord_x     <= rq.x;
		coord_y     <= rq.y;
		point_index <= rq.idx;
		seed_red    <= rq.r;
		seed_green  <= rq.g;
		seed_blue   <= rq.b;
		do @(posedge clk); while (busy);
		a = voronoi_answer(rq);
		awaited_answers = {awaited_answers, (typed ? typed_ans : a)};
		case (rq.op)
			FUNC_LOAD:     n_load++;
			FUNC_CLASSIFY: begin
				n_pixel++;
				if (a.err)
					n_empty++;
			end
			FUNC_QUERY:    n_query++;
			default:       n_bad++;
		endcase
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6))
				@(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
				$urandom_range(0, 8);
		end
	endtask

	// The register is only written once every request has been answered.
	task automatic write_num_points(logic [7:0] value);
		start <= 1'b0;
		while (awaited_answers.size() != 0)
			@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		np_setting  = value;
		n_cfg++;
	endtask

	always @(posedge clk) begin
		answer_t want, got;
		if (arst_n && done) begin
			got = {status, cell_res, red, green, blue, pixel_count};
			if (awaited_answers.size() == 0) begin
				n_fail++;
				if (n_fail <= 10)
					$display("%0t: result with no request outstanding: %s", $realtime,
						answer_text(got));
			end else begin
				want = awaited_answers.pop_front();
				n_checked++;
				if (got.err !== want.err || got.cell_no !== want.cell_no || got.r !== want.r ||
					got.g !== want.g || got.b !== want.b || got.cnt !== want.cnt) begin
					n_fail++;
					if (n_fail <= 10) begin
						$display("%0t: mismatch on result %0d", $realtime, n_checked);
						$display("  expected %s", answer_text(want));
						$display("  actual   %s", answer_text(got));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.", cycles,
				awaited_answers.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		step_row_t directed_steps [NUM_DIRECTED];
		int        np_plan [8];
		int        phase_len;
		directed_steps = '{
			'{1'b0, 8'd0, req(FUNC_QUERY, 0, 0, 0, 0, 0, 0),             1'b1, ans(0, 0, 0, 0, 0, 0)},
			'{1'b0, 8'd0, req(FUNC_QUERY, 0, 0, 127, 0, 0, 0),           1'b1, ans(0, 127, 0, 0, 0, 0)},
			'{1'b0, 8'd0, req(FUNC_BAD, 4095, 4095, 127, 255, 255, 255), 1'b1, ans(1, 0, 0, 0, 0, 0)},
			'{1'b0, 8'd0, req(FUNC_LOAD, 0, 0, 0, 'hff, 0, 0),           1'b1, ans(0, 0, 'hff, 0, 0, 0)},
			'{1'b0, 8'd0, req(FUNC_LOAD, 4095, 4095, 127, 0, 'hff, 'hff),
				1'b1, ans(0, 127, 0, 'hff, 'hff, 0)},
			'{1'b1, 8'd0, req(FUNC_CLASSIFY, 100, 200, 0, 0, 0, 0),      1'b1, ans(1, 0, 0, 0, 0, 0)},
			'{1'b1, 8'd1, req(FUNC_CLASSIFY, 4095, 4095, 0, 0, 0, 0),    1'b1, ans(0, 0, 'hff, 0, 0, 1)},
			'{1'b0, 8'd0, req(FUNC_CLASSIFY, 0, 0, 0, 0, 0, 0),          1'b1, ans(0, 0, 'hff, 0, 0, 2)},
			'{1'b0, 8'd0, req(FUNC_QUERY, 0, 0, 0, 0, 0, 0),             1'b1, ans(0, 0, 0, 0, 0, 2)},
			'{1'b0, 8'd0, req(FUNC_LOAD, 4095, 0, 1, 'h12, 'h34, 'h56),
				1'b1, ans(0, 1, 'h12, 'h34, 'h56, 0)},
			'{1'b0, 8'd0, req(FUNC_LOAD, 0, 4095, 2, 'hab, 'hcd, 'hef),
				1'b1, ans(0, 2, 'hab, 'hcd, 'hef, 0)},
			'{1'b0, 8'd0, req(FUNC_LOAD, 0, 0, 3, 1, 2, 3),              1'b1, ans(0, 3, 1, 2, 3, 0)},
			'{1'b1, 8'd4, req(FUNC_CLASSIFY, 2047, 2048, 0, 0, 0, 0),    1'b0, '0},
			'{1'b0, 8'd0, req(FUNC_CLASSIFY, 10, 10, 0, 0, 0, 0),        1'b0, '0},
			'{1'b0, 8'd0, req(FUNC_CLASSIFY, 2048, 0, 0, 0, 0, 0),       1'b0, '0},
			'{1'b0, 8'd0, req(FUNC_CLASSIFY, 4095, 4095, 0, 0, 0, 0),    1'b0, '0},
			'{1'b0, 8'd0, req(FUNC_LOAD, 5, 5, 0, 'h80, 'h80, 'h80),
				1'b1, ans(0, 0, 'h80, 'h80, 'h80, 0)},
			'{1'b0, 8'd0, req(FUNC_QUERY, 0, 0, 0, 0, 0, 0),             1'b1, ans(0, 0, 0, 0, 0, 0)},
			'{1'b0, 8'd0, req(FUNC_QUERY, 0, 0, 1, 0, 0, 0),             1'b0, '0},
			'{1'b1, 8'd2, req(FUNC_CLASSIFY, 4095, 0, 0, 0, 0, 0),       1'b0, '0},
			'{1'b0, 8'd0, req(FUNC_BAD, 0, 0, 0, 0, 0, 0),               1'b1, ans(1, 0, 0, 0, 0, 0)}
		};
		// A negative entry stands for a random setting between the extremes.
		np_plan = '{128, 255, 1, 0, 2, -1, 127, 100};

		arst_n      <= 1'b0;
		start       <= 1'b0;
		func        <= FUNC_LOAD;
		coord_x     <= '0;
		coord_y     <= '0;
		point_index <= '0;
		seed_red    <= '0;
		seed_green  <= '0;
		seed_blue   <= '0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		np_setting  = NUM_POINTS_RST;
		foreach (cell_hits[i])
			cell_hits[i] = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_steps[i]) begin
			if (directed_steps[i].set_np)
				write_num_points(directed_steps[i].np);
			send_request(directed_steps[i].rq, directed_steps[i].typed, directed_steps[i].ans);
		end

		// Every slot is loaded before any search can reach it.
		for (int s = 0; s < MAX_POINTS; s++)
			send_request(random_load(s), 1'b0, '0);

		foreach (np_plan[p]) begin
			write_num_points((np_plan[p] < 0) ? 8'($urandom_range(3, 126)) : 8'(np_plan[p]));
			phase_len = (np_plan[p] == 0) ? 60 : 120;
			repeat (phase_len)
				send_request(random_request(), 1'b0, '0);
		end

		start <= 1'b0;
		while (awaited_answers.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		n_fail += awaited_answers.size();

		$display("Covered %0d seed loads, %0d pixel searches (%0d with no seeds), %0d count reads",
			n_load, n_pixel, n_empty, n_query);
		$display("and %0d invalid requests; %0d results checked over %0d num_points settings.",
			n_bad, n_checked, n_cfg);
		if (n_fail == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== nearest_seed_voronoi_pixel_top.f =====
sv/nsv_pkg.sv
sv/nsv_front.sv
sv/nsv_back.sv
sv/nearest_seed_voronoi_pixel_top.sv
sv/nsv_checker.sv
tb/tb.sv
